// File: src/cbd_pkg.sv
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared codes and types for the chunked body decoder: parse phases,
// line-break characters and the result word passed from parser to output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbd_pkg;

  // parse phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_SIZE   = 3'd1;
  localparam logic [2:0] PH_DATA   = 3'd2;
  localparam logic [2:0] PH_SKIP   = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  // line-break characters
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;

  // beats in the closing CR LF CR LF, less the first one
  localparam logic [1:0] TERM_TAIL = 2'd3;

  // what one input beat produces
  typedef struct packed {
    logic       emit;   // one byte (or the terminator) goes out
    logic       term;   // emit the four-byte terminator
    logic [7:0] data;   // byte for a pass-through beat
    logic       sat;    // chunk size saturated
  } cbd_res_t;

endpackage

`default_nettype wire

// File: src/cbd_parse.sv
// ----------------------------------------------------------------------------
// cbd_parse
// Parse state of the chunked body decoder. Decodes the registered input beat
// combinationally and updates the state when that beat is consumed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbd_parse #(
  parameter int SIZE_BITS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            advance,
  input  wire logic [7:0]      beat_byte,
  input  wire logic            beat_start,
  output cbd_pkg::cbd_res_t    res
);

  localparam logic [SIZE_BITS-1:0] SIZE_MAX = {SIZE_BITS{1'b1}};

  logic [2:0]           phase_r,     phase_nxt;
  logic [1:0]           blank_r,     blank_nxt;
  logic [SIZE_BITS-1:0] chunk_r,     chunk_nxt;
  logic [SIZE_BITS-1:0] left_r,      left_nxt;
  logic                 dd_r,        dd_nxt;
  logic                 saw_cr_r,    saw_cr_nxt;
  logic [1:0]           skip_r,      skip_nxt;
  logic                 ovf_r,       ovf_nxt;

  logic [2:0]           ph;
  logic [1:0]           bm;
  logic [7:0]           pat_byte;
  logic                 is_hex;
  logic [3:0]           hex_val;

  // decode one hex digit
  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (beat_byte >= 8'h30 && beat_byte <= 8'h39) begin
      hex_val = 4'(beat_byte - 8'h30);
    end else if (beat_byte >= 8'h61 && beat_byte <= 8'h66) begin
      hex_val = 4'(beat_byte - 8'h57);
    end else if (beat_byte >= 8'h41 && beat_byte <= 8'h46) begin
      hex_val = 4'(beat_byte - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  // a message start restarts in the header
  assign ph       = beat_start ? cbd_pkg::PH_HEADER : phase_r;
  assign bm       = beat_start ? 2'd0 : blank_r;
  assign pat_byte = bm[0] ? cbd_pkg::CH_LF : cbd_pkg::CH_CR;

  // next state and result of the current beat
  always_comb begin
    phase_nxt  = ph;
    blank_nxt  = bm;
    chunk_nxt  = chunk_r;
    left_nxt   = left_r;
    dd_nxt     = dd_r;
    saw_cr_nxt = saw_cr_r;
    skip_nxt   = skip_r;
    ovf_nxt    = ovf_r;
    res        = '0;
    res.data   = beat_byte;

    unique case (ph)
      cbd_pkg::PH_HEADER: begin
        res.emit = 1'b1;
        if (beat_byte == pat_byte) begin
          if (bm == 2'd3) begin
            blank_nxt  = 2'd0;
            phase_nxt  = cbd_pkg::PH_SIZE;
            chunk_nxt  = '0;
            dd_nxt     = 1'b0;
            saw_cr_nxt = 1'b0;
            ovf_nxt    = 1'b0;
          end else begin
            blank_nxt = bm + 2'd1;
          end
        end else begin
          blank_nxt = (beat_byte == cbd_pkg::CH_CR) ? 2'd1 : 2'd0;
        end
      end

      cbd_pkg::PH_SIZE: begin
        if (!dd_r && is_hex) begin
          // accumulate, saturating when the top nibble is already in use
          if (chunk_r[SIZE_BITS-1 -: 4] != 4'd0) begin
            chunk_nxt = SIZE_MAX;
            ovf_nxt   = 1'b1;
          end else begin
            chunk_nxt = {chunk_r[SIZE_BITS-5:0], hex_val};
          end
        end else if (!dd_r && chunk_r == '0) begin
          // empty or zero size ends the message
          dd_nxt    = 1'b1;
          res.emit  = 1'b1;
          res.term  = 1'b1;
          phase_nxt = cbd_pkg::PH_DONE;
        end else begin
          dd_nxt = 1'b1;
          if (saw_cr_r && beat_byte == cbd_pkg::CH_LF) begin
            left_nxt   = chunk_r;
            saw_cr_nxt = 1'b0;
            phase_nxt  = cbd_pkg::PH_DATA;
          end else begin
            saw_cr_nxt = (beat_byte == cbd_pkg::CH_CR);
          end
        end
      end

      cbd_pkg::PH_DATA: begin
        res.emit = 1'b1;
        res.sat  = ovf_r;
        left_nxt = left_r - SIZE_BITS'(1);
        if (left_r == SIZE_BITS'(1)) begin
          skip_nxt  = 2'd2;
          phase_nxt = cbd_pkg::PH_SKIP;
        end
      end

      cbd_pkg::PH_SKIP: begin
        skip_nxt = skip_r - 2'd1;
        if (skip_r == 2'd1) begin
          phase_nxt  = cbd_pkg::PH_SIZE;
          chunk_nxt  = '0;
          dd_nxt     = 1'b0;
          saw_cr_nxt = 1'b0;
          ovf_nxt    = 1'b0;
        end
      end

      default: begin
        // finished or unused code: ignore input
      end
    endcase
  end

  // advance state when the beat is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= cbd_pkg::PH_HEADER;
      blank_r  <= 2'd0;
      chunk_r  <= '0;
      left_r   <= '0;
      dd_r     <= 1'b0;
      saw_cr_r <= 1'b0;
      skip_r   <= 2'd0;
      ovf_r    <= 1'b0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      blank_r  <= blank_nxt;
      chunk_r  <= chunk_nxt;
      left_r   <= left_nxt;
      dd_r     <= dd_nxt;
      saw_cr_r <= saw_cr_nxt;
      skip_r   <= skip_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// chunked_body_decoder
// Byte-wide decoder for HTTP chunked transfer coding.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one raw message byte per beat
//   with in_msg_start marking the first byte of a new message. Header bytes up
//   to the first blank line pass straight through; chunk-size lines and the
//   two bytes after each chunk are dropped; chunk data passes through with
//   out_size_saturated showing a clipped size. A zero size ends the message
//   with CR LF CR LF, out_last on the final byte; later bytes are dropped
//   until the next message start.
//   An input beat passes through the input register, then the output
//   register. One byte is taken every cycle unless in_stall is high; a
//   message end occupies the output register for four beats, and input
//   stalls for three of them if a further byte needs the output.
//   Bytes that produce nothing are consumed without waiting on the output.
//   When out_stall is high the output beat holds and the input register
//   fills, after which in_stall rises in the same cycle.
//   Synchronous reset (rst_n low) empties both registers and returns the
//   parser to the header phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chunked_body_decoder #(
  parameter int SIZE_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_msg_start,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic [7:0] out_byte,
  output      logic       out_last,
  output      logic       out_size_saturated
);

  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              s1_start_r;
  logic              s1_take;
  logic              s2_free;
  logic              in_take;

  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_last_r;
  logic              out_sat_r;
  logic [1:0]        term_left_r;

  cbd_pkg::cbd_res_t res;

  // decode the registered beat
  cbd_parse #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (s1_valid_r && s1_take),
    .beat_byte  (s1_byte_r),
    .beat_start (s1_start_r),
    .res        (res)
  );

  // handshake between the two registers
  assign s2_free  = !out_valid_r || (!out_stall && term_left_r == 2'd0);
  assign s1_take  = !res.emit || s2_free;
  assign in_stall = s1_valid_r && !s1_take;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r  <= in_byte;
      s1_start_r <= in_msg_start;
    end
  end

  // output register: load a result or step through the terminator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      term_left_r <= 2'd0;
      out_byte_r  <= 8'd0;
      out_last_r  <= 1'b0;
      out_sat_r   <= 1'b0;
    end else if (s1_valid_r && s1_take && res.emit) begin
      out_valid_r <= 1'b1;
      out_byte_r  <= res.term ? cbd_pkg::CH_CR : res.data;
      out_last_r  <= 1'b0;
      out_sat_r   <= res.sat && !res.term;
      term_left_r <= res.term ? cbd_pkg::TERM_TAIL : 2'd0;
    end else if (out_valid_r && !out_stall) begin
      if (term_left_r != 2'd0) begin
        out_byte_r  <= term_left_r[0] ? cbd_pkg::CH_LF : cbd_pkg::CH_CR;
        out_last_r  <= (term_left_r == 2'd1);
        out_sat_r   <= 1'b0;
        term_left_r <= term_left_r - 2'd1;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_last           = out_last_r;
  assign out_size_saturated = out_sat_r;

  // checks
  a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_byte_r == cbd_pkg::CH_LF && term_left_r == 2'd0)
    else $error("last beat is not the closing LF");

  a_term_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    term_left_r != 2'd0 |-> out_valid_r && !out_last_r)
    else $error("terminator pending without a valid output beat");

  a_stalled_beat_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> s1_valid_r && $stable(s1_byte_r) && $stable(s1_start_r))
    else $error("held input beat lost while stalled");

  a_term_sat_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && term_left_r != 2'd0 |-> !out_sat_r)
    else $error("saturation flag set on a terminator beat");

endmodule

`default_nettype wire

// File: dv/tb_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// tb_chunked_body_decoder
// Self-checking bench for the chunked body decoder. Whole messages are built
// byte by byte (header, size lines with extensions, chunk data, the zero-size
// end) and fed with bursty valid. A scoreboard re-derives the decoded stream
// from every accepted beat. Every output beat is compared against the oldest
// outstanding prediction while the output side stalls on its own schedule,
// including one long hold-off that backs the decoder up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_chunked_body_decoder;

  localparam int SIZE_W      = 32;
  localparam int LIMIT       = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_BEATS  = 170;

  // ASCII ranges for hex digits and printable text
  localparam logic [7:0] ASC_ZERO  = 8'h30;
  localparam logic [7:0] ASC_NINE  = 8'h39;
  localparam logic [7:0] ASC_LOW_A = 8'h61;
  localparam logic [7:0] ASC_LOW_F = 8'h66;
  localparam logic [7:0] ASC_UP_A  = 8'h41;
  localparam logic [7:0] ASC_UP_F  = 8'h46;
  localparam logic [7:0] ASC_SPACE = 8'h20;
  localparam logic [7:0] ASC_TILDE = 8'h7e;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_style_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       sat;
  } dec_beat_t;

  // Scoreboard: mirrors the decoder's parse state and queues the beats due out
  class cbd_scoreboard;
    logic [2:0]  phase;
    logic [1:0]  crlf_seen;
    logic [63:0] size_acc;
    logic [63:0] data_left;
    logic        digits_done;
    logic        saw_cr;
    logic [1:0]  skip_left;
    logic        size_clipped;
    dec_beat_t   expected_q[$];
    int          errors;
    int          beats_in;
    int          beats_out;
    int          msgs;
    int          terminators;
    int          clipped_beats;

    function new();
      errors        = 0;
      beats_in      = 0;
      beats_out     = 0;
      msgs          = 0;
      terminators   = 0;
      clipped_beats = 0;
      restart();
    endfunction

    function void restart();
      phase        = cbd_pkg::PH_HEADER;
      crlf_seen    = 2'd0;
      size_acc     = 64'd0;
      data_left    = 64'd0;
      digits_done  = 1'b0;
      saw_cr       = 1'b0;
      skip_left    = 2'd0;
      size_clipped = 1'b0;
    endfunction

    function void open_size_line();
      phase        = cbd_pkg::PH_SIZE;
      size_acc     = 64'd0;
      digits_done  = 1'b0;
      saw_cr       = 1'b0;
      size_clipped = 1'b0;
    endfunction

    function void push_expect(logic [7:0] b, logic l, logic s);
      dec_beat_t e;
      e.data = b;
      e.last = l;
      e.sat  = s;
      expected_q.push_back(e);
    endfunction

    // Advance the parse by one accepted input beat
    function void note_input(logic [7:0] b, logic st);
      int          nib;
      logic [63:0] size_max;
      logic        line_open;
      beats_in++;
      if (st) begin
        restart();
        msgs++;
      end
      case (phase)
        cbd_pkg::PH_HEADER: begin
          push_expect(b, 1'b0, 1'b0);
          // CR LF CR LF search, restarting on CR so overlaps are caught
          if (b == (crlf_seen[0] ? cbd_pkg::CH_LF : cbd_pkg::CH_CR)) begin
            if (crlf_seen == 2'd3) begin
              crlf_seen = 2'd0;
              open_size_line();
            end else begin
              crlf_seen = crlf_seen + 2'd1;
            end
          end else begin
            crlf_seen = (b == cbd_pkg::CH_CR) ? 2'd1 : 2'd0;
          end
        end
        cbd_pkg::PH_SIZE: begin
          line_open = 1'b1;
          if (!digits_done) begin
            nib = -1;
            if (b >= ASC_ZERO && b <= ASC_NINE) nib = b - ASC_ZERO;
            else if (b >= ASC_LOW_A && b <= ASC_LOW_F) nib = b - ASC_LOW_A + 10;
            else if (b >= ASC_UP_A && b <= ASC_UP_F) nib = b - ASC_UP_A + 10;
            if (nib >= 0) begin
              // accumulate, clipping at the size width
              size_max = ~64'd0 >> (64 - SIZE_W);
              if (size_acc > ((size_max - 64'(nib)) >> 4)) begin
                size_acc     = size_max;
                size_clipped = 1'b1;
              end else begin
                size_acc = (size_acc << 4) | 64'(nib);
              end
              line_open = 1'b0;
            end else begin
              digits_done = 1'b1;
              if (size_acc == 64'd0) begin
                // zero size: close the message straight away
                push_expect(cbd_pkg::CH_CR, 1'b0, 1'b0);
                push_expect(cbd_pkg::CH_LF, 1'b0, 1'b0);
                push_expect(cbd_pkg::CH_CR, 1'b0, 1'b0);
                push_expect(cbd_pkg::CH_LF, 1'b1, 1'b0);
                terminators++;
                phase     = cbd_pkg::PH_DONE;
                line_open = 1'b0;
              end
            end
          end
          // skip extensions up to CR LF
          if (line_open) begin
            if (saw_cr && b == cbd_pkg::CH_LF) begin
              data_left = size_acc;
              saw_cr    = 1'b0;
              phase     = cbd_pkg::PH_DATA;
            end else begin
              saw_cr = (b == cbd_pkg::CH_CR);
            end
          end
        end
        cbd_pkg::PH_DATA: begin
          push_expect(b, 1'b0, size_clipped);
          if (size_clipped) clipped_beats++;
          data_left = data_left - 64'd1;
          if (data_left == 64'd0) begin
            skip_left = 2'd2;
            phase     = cbd_pkg::PH_SKIP;
          end
        end
        cbd_pkg::PH_SKIP: begin
          skip_left = skip_left - 2'd1;
          if (skip_left == 2'd0) open_size_line();
        end
        default: ;
      endcase
    endfunction

    task report(input string what);
      errors++;
      $display("ERROR [%0t] %s", $time, what);
    endtask

    // Compare one output beat with the oldest prediction
    task check_result(input logic [7:0] data, input logic last, input logic sat);
      dec_beat_t e;
      beats_out++;
      if (expected_q.size() == 0) begin
        report($sformatf("output beat %02h with nothing expected", data));
        return;
      end
      e = expected_q.pop_front();
      if (data !== e.data)
        report($sformatf("out_byte %02h, expected %02h", data, e.data));
      if (last !== e.last)
        report($sformatf("out_last %b on byte %02h, expected %b", last, data, e.last));
      if (sat !== e.sat)
        report($sformatf("out_size_saturated %b on byte %02h, expected %b", sat, data, e.sat));
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_msg_start;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_size_saturated;

  cbd_scoreboard sb;
  logic [7:0]    msg_bytes[$];
  int            burst_left = 1;
  bit            steady     = 1'b0;
  bit            hold_req   = 1'b0;
  int            cycles     = 0;

  chunked_body_decoder #(
    .SIZE_BITS(SIZE_W)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .in_msg_start      (in_msg_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_last          (out_last),
    .out_size_saturated(out_size_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("ERROR: run exceeded %0d cycles with %0d beats outstanding",
               LIMIT, sb.expected_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Check every output beat taken
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(out_byte, out_last, out_size_saturated);
  end

  // Output side: shifting stall styles, plus one long hold-off on request
  initial begin : receiver
    int           pace_left;
    stall_style_t style;
    pace_left = 0;
    style     = STALL_NONE;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        if (pace_left == 0) begin
          style     = stall_style_t'($urandom_range(0, 3));
          pace_left = $urandom_range(16, 96);
        end
        pace_left--;
        case (style)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Offer one beat, hold it until taken, then maybe pause between bursts
  task automatic push_byte(input logic [7:0] b, input logic st);
    in_valid     <= 1'b1;
    in_byte      <= b;
    in_msg_start <= st;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_input(b, st);
    if (!steady) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  task automatic send_message();
    foreach (msg_bytes[i]) push_byte(msg_bytes[i], i == 0);
    msg_bytes.delete();
  endtask

  function automatic logic [7:0] hex_char(input int nib);
    if (nib < 10) return ASC_ZERO + 8'(nib);
    return (($urandom_range(0, 1) != 0) ? ASC_UP_A : ASC_LOW_A) + 8'(nib - 10);
  endfunction

  function automatic logic [7:0] noisy_byte();
    case ($urandom_range(0, 5))
      0:       return cbd_pkg::CH_CR;
      1:       return cbd_pkg::CH_LF;
      2:       return hex_char($urandom_range(0, 15));
      3:       return ASC_SPACE + 8'($urandom_range(0, 94));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
  endtask

  task automatic add_crlf();
    msg_bytes.push_back(cbd_pkg::CH_CR);
    msg_bytes.push_back(cbd_pkg::CH_LF);
  endtask

  // Size in hex with random case and optional leading zeros
  task automatic add_hex(input int unsigned v, input int pad);
    logic [7:0]  digs[$];
    int unsigned r;
    r = v;
    do begin
      digs.push_front(hex_char(r % 16));
      r = r / 16;
    end while (r != 0);
    repeat (pad) digs.push_front(ASC_ZERO);
    foreach (digs[i]) msg_bytes.push_back(digs[i]);
  endtask

  // Chunk extension, sometimes with a stray CR that must not end the line
  task automatic add_extension();
    case ($urandom_range(0, 5))
      0: add_text(";name=val");
      1: begin
        msg_bytes.push_back(ASC_SPACE);
        repeat ($urandom_range(1, 4)) msg_bytes.push_back(ASC_SPACE + 8'($urandom_range(0, 94)));
      end
      2: begin
        add_text(";a");
        msg_bytes.push_back(cbd_pkg::CH_CR);
        add_text("b");
      end
      default: ;
    endcase
  endtask

  task automatic add_header();
    repeat ($urandom_range(0, 12)) msg_bytes.push_back(noisy_byte());
    add_crlf();
    add_crlf();
  endtask

  // Well-formed message, or one whose first chunk size overflows and never ends
  task automatic build_message(input bit clip);
    int n_chunks;
    int size;
    add_header();
    if (clip) begin
      msg_bytes.push_back(hex_char($urandom_range(1, 15)));
      repeat ($urandom_range(8, 11)) msg_bytes.push_back(hex_char($urandom_range(0, 15)));
      add_extension();
      add_crlf();
      repeat ($urandom_range(1, 6)) msg_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    n_chunks = $urandom_range(1, 3);
    repeat (n_chunks) begin
      size = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      add_hex(size, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
      add_extension();
      add_crlf();
      repeat (size) msg_bytes.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) != 0) begin
        add_crlf();
      end else begin
        msg_bytes.push_back(noisy_byte());
        msg_bytes.push_back(noisy_byte());
      end
    end
    // last chunk: zero, or a size line with no digit at all
    if ($urandom_range(0, 3) == 0) begin
      add_extension();
    end else begin
      add_hex(0, $urandom_range(0, 1));
    end
    add_extension();
    add_crlf();
    add_crlf();
  endtask

  initial begin : main
    int kind;
    int random_items;
    in_valid     <= 1'b0;
    in_byte      <= 8'h00;
    in_msg_start <= 1'b0;
    rst_n        <= 1'b0;
    sb           = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    burst_left = $urandom_range(1, 24);

    // Directed: byte extremes, overlapping blank line, extension, unchecked
    // trailer bytes, a "0x" prefix that closes at once, and ignored tail
    msg_bytes.push_back(8'hff);
    msg_bytes.push_back(cbd_pkg::CH_CR);
    add_crlf();
    add_crlf();
    add_text("1;");
    add_crlf();
    msg_bytes.push_back(8'h00);
    add_crlf();
    add_text("0x");
    msg_bytes.push_back(8'h7f);
    send_message();

    // Directed: size saturates across mixed-case digits, restart mid-data
    add_crlf();
    add_crlf();
    add_text("fFFFFFFFF");
    add_crlf();
    msg_bytes.push_back(8'h5a);
    msg_bytes.push_back(8'ha5);
    send_message();

    // Random messages; the output side backs off hard near the start
    hold_req     = 1'b1;
    random_items = 0;
    while (random_items < RAND_BEATS) begin
      steady = ($urandom_range(0, 3) == 0);
      kind   = $urandom_range(0, 9);
      if (kind < 7) begin
        build_message(1'b0);
      end else if (kind == 7) begin
        build_message(1'b0);
        kind = $urandom_range(1, msg_bytes.size() - 1);
        while (msg_bytes.size() > kind) void'(msg_bytes.pop_back());
      end else if (kind == 8) begin
        build_message(1'b1);
      end else begin
        repeat ($urandom_range(4, 20)) msg_bytes.push_back(noisy_byte());
      end
      random_items += msg_bytes.size();
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 5)) msg_bytes.push_back(noisy_byte());
      send_message();
    end
    in_valid <= 1'b0;

    // Drain, then give any stray beats time to show up
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d input beats over %0d messages; %0d output beats checked.",
             sb.beats_in, sb.msgs, sb.beats_out);
    $display("Saw %0d message terminators and %0d data beats from saturated sizes.",
             sb.terminators, sb.clipped_beats);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches found", sb.errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
